// ----- sv/tdi_pkg.sv -----
// Shared constants and controller/datapath interface types for the tile dedup indexer.
`default_nettype none

package tdi_pkg;

    // Dictionary geometry
    localparam int MAX_TILES       = 64;
    localparam int MAX_TILE_PIXELS = 64;
    localparam int TILE_W          = $clog2(MAX_TILES);
    localparam int CNT_W           = TILE_W + 1;
    localparam int POS_W           = $clog2(MAX_TILE_PIXELS);
    localparam int ADDR_W          = TILE_W + POS_W;

    // Field widths
    localparam int PIX_W  = 32;
    localparam int LEN_W  = 7;
    localparam int IDX_W  = 7;
    localparam int OCC_W  = 16;
    localparam int DIST_W = 7;

    localparam logic [OCC_W-1:0] OCC_MAX         = {OCC_W{1'b1}};
    localparam logic [LEN_W-1:0] TILE_PIXELS_RST = LEN_W'(MAX_TILE_PIXELS);

    // Controller to datapath commands
    typedef struct packed {
        logic accept;    // load the incoming pixel beat
        logic rd_issue;  // read stored tile k at the current position
        logic wr_pix;    // write pixel into the free slot
        logic pix_next;  // advance to the next pixel position
        logic scan_step; // test one mismatch bit during the match search
        logic occ_upd;   // update occurrence count and form the result
        logic out_load;  // move the result into the output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic stored_zero;
        logic rd_last;
        logic tile_end;
        logic scan_hit;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ----- sv/tdi_ram.sv -----
// Generic single-port RAM with registered read data.
`default_nettype none

module tdi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

// ----- sv/tdi_ctrl.sv -----
// Sequencing state machine for the tile dedup indexer.
`default_nettype none

module tdi_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire tdi_pkg::t_sts i_sts,
    output tdi_pkg::t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_SCAN,
        ST_OCC_RD,
        ST_OCC_UPD,
        ST_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_tready = (r_state == ST_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_READ;
                end
            end
            ST_READ: begin
                if (i_sts.stored_zero) begin
                    n_state = ST_WRITE;
                end else begin
                    o_cmd.rd_issue = 1'b1;
                    if (i_sts.rd_last) begin
                        n_state = ST_WRITE;
                    end
                end
            end
            ST_WRITE: begin
                o_cmd.wr_pix = 1'b1;
                if (i_sts.tile_end) begin
                    n_state = ST_SCAN;
                end else begin
                    o_cmd.pix_next = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_hit) begin
                    n_state = ST_OCC_RD;
                end else if (i_sts.scan_done) begin
                    n_state = ST_OCC_UPD;
                end
            end
            ST_OCC_RD: begin
                n_state = ST_OCC_UPD;
            end
            ST_OCC_UPD: begin
                o_cmd.occ_upd = 1'b1;
                n_state       = ST_RESULT;
            end
            ST_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- sv/tdi_dp.sv -----
// Datapath: tile store, mismatch map, match search, occurrence counts, output register.
`default_nettype none

module tdi_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire tdi_pkg::t_cmd                i_cmd,
    output tdi_pkg::t_sts                     o_sts,
    input  wire logic                         i_cfg_valid,
    input  wire logic [tdi_pkg::LEN_W-1:0]    i_cfg_data,
    input  wire logic [tdi_pkg::PIX_W-1:0]    i_pixel_rgba,
    input  wire logic                         i_tile_end,
    input  wire logic                         i_image_start,
    input  wire logic                         i_m_tready,
    output logic                              o_m_tvalid,
    output logic      [tdi_pkg::IDX_W-1:0]    o_tile_index,
    output logic                              o_is_new,
    output logic                              o_table_full,
    output logic      [tdi_pkg::OCC_W-1:0]    o_occurrences,
    output logic      [tdi_pkg::DIST_W-1:0]   o_distinct_count
);

    localparam int TW = tdi_pkg::TILE_W;
    localparam int CW = tdi_pkg::CNT_W;
    localparam int PW = tdi_pkg::POS_W;
    localparam int LW = tdi_pkg::LEN_W;
    localparam int OW = tdi_pkg::OCC_W;

    // Control state
    logic [LW-1:0]                 r_tile_pixels;
    logic [PW-1:0]                 r_pos;
    logic [CW-1:0]                 r_stored;
    logic [tdi_pkg::MAX_TILES-1:0] r_mismatch;
    logic [CW-1:0]                 r_k;
    logic                          r_found;
    logic                          r_end;
    logic                          r_rd_pend;

    // Payload
    logic [tdi_pkg::PIX_W-1:0]     r_pix;
    logic [TW-1:0]                 r_rd_k;
    logic [tdi_pkg::IDX_W-1:0]     r_res_idx;
    logic                          r_res_new;
    logic                          r_res_full;
    logic [OW-1:0]                 r_res_occ;
    logic [tdi_pkg::DIST_W-1:0]    r_res_dist;

    logic [LW-1:0]                 len_eff;
    logic [PW-1:0]                 pos_in;
    logic                          end_in;
    logic                          table_full;
    logic                          scan_hit;
    logic                          scan_done;
    logic [tdi_pkg::ADDR_W-1:0]    tile_addr;
    logic                          tile_we;
    logic [tdi_pkg::PIX_W-1:0]     tile_rdata;
    logic [TW-1:0]                 occ_addr;
    logic                          occ_we;
    logic [OW-1:0]                 occ_wdata;
    logic [OW-1:0]                 occ_rdata;
    logic [OW-1:0]                 occ_inc;

    // Tile length clamped to 1..MAX_TILE_PIXELS
    always_comb begin
        if (r_tile_pixels == '0) begin
            len_eff = LW'(1);
        end else if (r_tile_pixels > LW'(tdi_pkg::MAX_TILE_PIXELS)) begin
            len_eff = LW'(tdi_pkg::MAX_TILE_PIXELS);
        end else begin
            len_eff = r_tile_pixels;
        end
    end

    assign pos_in     = i_image_start ? '0 : r_pos;
    assign end_in     = i_tile_end || ((LW'(pos_in) + LW'(1)) >= len_eff);
    assign table_full = (r_stored >= CW'(tdi_pkg::MAX_TILES));
    assign scan_done  = (r_k >= r_stored);
    assign scan_hit   = !scan_done && !r_mismatch[r_k[TW-1:0]];

    // Status to the controller
    assign o_sts.stored_zero = (r_stored == '0);
    assign o_sts.rd_last     = ((r_k + CW'(1)) == r_stored);
    assign o_sts.tile_end    = r_end;
    assign o_sts.scan_hit    = scan_hit;
    assign o_sts.scan_done   = scan_done;
    assign o_sts.out_free    = !o_m_tvalid || i_m_tready;

    // Tile store: reads walk the stored tiles, the write fills the free slot
    assign tile_addr = i_cmd.wr_pix ? {r_stored[TW-1:0], r_pos} : {r_k[TW-1:0], r_pos};
    assign tile_we   = i_cmd.wr_pix && !table_full;

    tdi_ram #(
        .WIDTH (tdi_pkg::PIX_W),
        .DEPTH (tdi_pkg::MAX_TILES * tdi_pkg::MAX_TILE_PIXELS)
    ) u_tile_ram (
        .i_clk   (i_clk),
        .i_we    (tile_we),
        .i_addr  (tile_addr),
        .i_wdata (r_pix),
        .o_rdata (tile_rdata)
    );

    // Occurrence counts: increment on a match, start at one for a new tile
    assign occ_inc   = (occ_rdata == tdi_pkg::OCC_MAX) ? occ_rdata : occ_rdata + OW'(1);
    assign occ_addr  = (i_cmd.occ_upd && !r_found) ? r_stored[TW-1:0] : r_k[TW-1:0];
    assign occ_we    = i_cmd.occ_upd && (r_found || !table_full);
    assign occ_wdata = r_found ? occ_inc : OW'(1);

    tdi_ram #(
        .WIDTH (OW),
        .DEPTH (tdi_pkg::MAX_TILES)
    ) u_occ_ram (
        .i_clk   (i_clk),
        .i_we    (occ_we),
        .i_addr  (occ_addr),
        .i_wdata (occ_wdata),
        .o_rdata (occ_rdata)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_pixels <= tdi_pkg::TILE_PIXELS_RST;
            r_pos         <= '0;
            r_stored      <= '0;
            r_mismatch    <= '0;
            r_k           <= '0;
            r_found       <= 1'b0;
            r_end         <= 1'b0;
            r_rd_pend     <= 1'b0;
            o_m_tvalid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_tile_pixels <= i_cfg_data;
            end
            r_rd_pend <= i_cmd.rd_issue;

            // Compare the returned word, one stored tile per beat
            if (r_rd_pend && (tile_rdata != r_pix)) begin
                r_mismatch[r_rd_k] <= 1'b1;
            end

            if (i_cmd.accept) begin
                r_pos   <= pos_in;
                r_end   <= end_in;
                r_k     <= '0;
                r_found <= 1'b0;
                if (i_image_start) begin
                    r_stored   <= '0;
                    r_mismatch <= '0;
                end
            end

            if (i_cmd.rd_issue) begin
                r_k <= r_k + CW'(1);
            end
            if (i_cmd.wr_pix) begin
                r_k <= '0;
            end
            if (i_cmd.pix_next) begin
                r_pos <= r_pos + PW'(1);
            end

            // Lowest stored tile with no mismatch
            if (i_cmd.scan_step) begin
                if (scan_hit) begin
                    r_found <= 1'b1;
                end else if (!scan_done) begin
                    r_k <= r_k + CW'(1);
                end
            end

            if (i_cmd.occ_upd && !r_found && !table_full) begin
                r_stored <= r_stored + CW'(1);
            end

            // Output register and end-of-tile cleanup
            if (i_cmd.out_load) begin
                o_m_tvalid <= 1'b1;
                r_mismatch <= '0;
                r_pos      <= '0;
            end else if (i_m_tready) begin
                o_m_tvalid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pix <= i_pixel_rgba;
        end
        if (i_cmd.rd_issue) begin
            r_rd_k <= r_k[TW-1:0];
        end
        if (i_cmd.occ_upd) begin
            if (r_found) begin
                r_res_idx  <= tdi_pkg::IDX_W'(r_k);
                r_res_new  <= 1'b0;
                r_res_full <= 1'b0;
                r_res_occ  <= occ_inc;
                r_res_dist <= tdi_pkg::DIST_W'(r_stored);
            end else if (!table_full) begin
                r_res_idx  <= tdi_pkg::IDX_W'(r_stored);
                r_res_new  <= 1'b1;
                r_res_full <= 1'b0;
                r_res_occ  <= OW'(1);
                r_res_dist <= tdi_pkg::DIST_W'(r_stored + CW'(1));
            end else begin
                r_res_idx  <= tdi_pkg::IDX_W'(tdi_pkg::MAX_TILES);
                r_res_new  <= 1'b0;
                r_res_full <= 1'b1;
                r_res_occ  <= '0;
                r_res_dist <= tdi_pkg::DIST_W'(r_stored);
            end
        end
        if (i_cmd.out_load) begin
            o_tile_index     <= r_res_idx;
            o_is_new         <= r_res_new;
            o_table_full     <= r_res_full;
            o_occurrences    <= r_res_occ;
            o_distinct_count <= r_res_dist;
        end
    end

endmodule

`default_nettype wire

// ----- sv/tile_dedup_indexer_unit.sv -----
// Top level of the tile dedup indexer: stream ports, controller and datapath.
//
// Usage: RGBA pixel beats enter on the s_axis channel, tile by tile. tlast marks the
// last pixel of a tile (a tile also ends at the configured length), tuser marks the
// first pixel of a new image and empties the dictionary. Each pixel is compared with
// the pixel at the same place of every stored tile, one tile-store read per cycle.
// At the end of a tile one result beat leaves on m_axis: dictionary index, new flag,
// table-full flag, occurrence count and number of distinct tiles.
// The cfg channel writes the tile length in pixels (reset 64); it is always ready.
// The user must write it only while the block is idle; the block does not enforce it.
// A pixel is accepted, then the single tile-store port reads every stored tile, then
// the pixel is written into the free slot unless the table is full. The last pixel
// of a tile adds the match search, the occurrence count update and the result load.
// Pixel beats are taken one at a time; s_axis tready is high while waiting for one.
// A result waits in the output register when the receiver stalls; the next tile
// proceeds until its own result needs that register.
// Reset (synchronous, active low) empties the dictionary and sets the length to 64.
`default_nettype none

module tile_dedup_indexer_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Pixel input
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // [31:0] pixel_rgba
    input  wire logic        i_s_axis_tlast,   // tile_end
    input  wire logic        i_s_axis_tuser,   // [0] image_start
    // Result output
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [31:0] o_m_axis_tdata,   // [6:0] tile_index, [22:7] occurrences,
                                               // [29:23] distinct_count, [31:30] zero
    output logic      [1:0]  o_m_axis_tuser,   // [0] is_new, [1] table_full
    // Tile length register
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [6:0]  i_cfg_data        // [6:0] tile_pixels
);

    tdi_pkg::t_cmd cmd;
    tdi_pkg::t_sts sts;

    logic [tdi_pkg::IDX_W-1:0]  tile_index;
    logic                       is_new;
    logic                       table_full;
    logic [tdi_pkg::OCC_W-1:0]  occurrences;
    logic [tdi_pkg::DIST_W-1:0] distinct_count;

    assign o_cfg_ready = 1'b1;

    tdi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tdi_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_pixel_rgba     (i_s_axis_tdata),
        .i_tile_end       (i_s_axis_tlast),
        .i_image_start    (i_s_axis_tuser),
        .i_m_tready       (i_m_axis_tready),
        .o_m_tvalid       (o_m_axis_tvalid),
        .o_tile_index     (tile_index),
        .o_is_new         (is_new),
        .o_table_full     (table_full),
        .o_occurrences    (occurrences),
        .o_distinct_count (distinct_count)
    );

    // Result beat packing
    assign o_m_axis_tdata = {2'b00, distinct_count, occurrences, tile_index};
    assign o_m_axis_tuser = {table_full, is_new};

endmodule

`default_nettype wire
